/* hdl/stepper_uart_datagram_framer_macros.svh */
// Assertion macros used by the datagram framer checker.
`ifndef STEPPER_UART_DATAGRAM_FRAMER_MACROS_SVH
`define STEPPER_UART_DATAGRAM_FRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SUDF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sudf assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define SUDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sudf assertion failed");

`endif

/* hdl/sudf_pkg.sv */
// Types, constants and the CRC step shared by the datagram framer.
package sudf_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hA0;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] MAX_SLAVE  = 8'd3;

  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  // Byte positions inside a datagram.
  localparam logic [2:0] IDX_SYNC       = 3'd0;
  localparam logic [2:0] IDX_SLAVE      = 3'd1;
  localparam logic [2:0] IDX_REG        = 3'd2;
  localparam logic [2:0] IDX_DATA3      = 3'd3;
  localparam logic [2:0] IDX_DATA2      = 3'd4;
  localparam logic [2:0] IDX_DATA1      = 3'd5;
  localparam logic [2:0] IDX_DATA0      = 3'd6;
  localparam logic [2:0] IDX_READ_LAST  = 3'd3;
  localparam logic [2:0] IDX_WRITE_LAST = 3'd7;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  slave_address;
    logic [6:0]  register_address;
    logic [31:0] data_word;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       rejected;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Classified request as it waits in the queue.
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  slave;
    logic [7:0]  reg_byte;
    logic [31:0] data;
  } cmd_t;

  // One byte through CRC-8, fed least significant bit first.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in,
                                          input logic [7:0] data_in);
    logic [7:0] crc;
    crc = crc_in;
    for (int b = 0; b < 8; b++) begin
      if (crc[7] ^ data_in[b]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* hdl/stepper_uart_datagram_framer.sv */
// Register datagram framer: sync, slave, register, write data and CRC-8 bytes.
// A request goes through front register, queue and back stage to the output.
// Bytes leave one per cycle unless rsp_ready stalls them; a write has 8 bytes,
// a read 4, a reject 1, and requests queue up behind it in the meantime.
// Synchronous reset empties the front register, the queue and the output.
module stepper_uart_datagram_framer #(
  parameter int unsigned QUEUE_DEPTH = sudf_pkg::DEF_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sudf_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output sudf_pkg::rsp_t  rsp
);
  import sudf_pkg::*;

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  sudf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd)
  );

  sudf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  sudf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_cmd   (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* hdl/sudf_front.sv */
// Front stage: accepts register requests and classifies them into commands.
module sudf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sudf_pkg::req_t  req,
  output logic            push_valid,
  input  logic            push_ready,
  output sudf_pkg::cmd_t  push_cmd
);
  import sudf_pkg::*;

  logic valid;
  cmd_t cmd;
  cmd_t cmd_next;

  assign req_ready  = !valid || push_ready;
  assign push_valid = valid;
  assign push_cmd   = cmd;

  always_comb begin
    cmd_next.slave    = req.slave_address[1:0];
    cmd_next.reg_byte = {req.req_type, req.register_address};
    cmd_next.data     = req.data_word;
    if (req.slave_address > MAX_SLAVE) begin
      cmd_next.kind = KIND_REJECT;
    end else if (req.req_type) begin
      cmd_next.kind = KIND_WRITE;
    end else begin
      cmd_next.kind = KIND_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_ready) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

/* hdl/sudf_queue.sv */
// Short command queue between the front and back stages.
module sudf_queue #(
  parameter int unsigned DEPTH = sudf_pkg::DEF_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  sudf_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sudf_pkg::cmd_t  pop_cmd
);
  import sudf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* hdl/sudf_back.sv */
// Back stage: walks one command into datagram bytes with a running CRC.
module sudf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  sudf_pkg::cmd_t  pop_cmd,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output sudf_pkg::rsp_t  rsp
);
  import sudf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t     state;
  cmd_t       cur;
  logic [2:0] idx;
  logic [7:0] crc;
  logic [7:0] byte_sel;
  logic       cur_last;
  logic       cur_rej;
  logic       out_free;
  logic       emit;
  logic       sending;

  always_comb begin
    case (idx)
      IDX_SYNC:  byte_sel = SYNC_BYTE;
      IDX_SLAVE: byte_sel = {6'b0, cur.slave};
      IDX_REG:   byte_sel = cur.reg_byte;
      IDX_DATA3: byte_sel = cur.data[31:24];
      IDX_DATA2: byte_sel = cur.data[23:16];
      IDX_DATA1: byte_sel = cur.data[15:8];
      IDX_DATA0: byte_sel = cur.data[7:0];
      default:   byte_sel = crc;
    endcase
    cur_rej  = 1'b0;
    cur_last = 1'b0;
    unique case (cur.kind)
      KIND_READ: begin
        cur_last = (idx == IDX_READ_LAST);
        if (cur_last) begin
          byte_sel = crc;
        end
      end
      KIND_WRITE: begin
        cur_last = (idx == IDX_WRITE_LAST);
      end
      default: begin
        cur_rej  = 1'b1;
        cur_last = 1'b1;
        byte_sel = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      ST_SEND: sending = 1'b1;
      default: sending = 1'b0;
    endcase
  end

  assign out_free  = !rsp_valid || rsp_ready;
  assign emit      = sending && out_free;
  // Take the next command on the same edge the final byte leaves.
  assign pop_ready = !sending || (emit && cur_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (out_free) begin
        rsp_valid <= emit;
      end
      if (pop_ready) begin
        state <= pop_valid ? ST_SEND : ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.tx_byte  <= byte_sel;
      rsp.last     <= cur_last;
      rsp.rejected <= cur_rej;
      idx          <= idx + 3'd1;
      crc          <= crc_feed(crc, byte_sel);
    end
    if (pop_ready && pop_valid) begin
      cur <= pop_cmd;
      idx <= IDX_SYNC;
      crc <= '0;
    end
  end

endmodule

/* hdl/sudf_checker.sv */
// Port-level checks on the datagram framer and their bind.
`include "stepper_uart_datagram_framer_macros.svh"

module sudf_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input sudf_pkg::req_t  req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input sudf_pkg::rsp_t  rsp
);
  import sudf_pkg::*;

  logic expect_sync;

  // Track whether the next delivered byte opens a datagram.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_sync <= 1'b1;
    end else if (rsp_valid && rsp_ready) begin
      expect_sync <= rsp.last;
    end
  end

  `SUDF_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))
  `SUDF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `SUDF_ASSERT_IMP(a_reject_shape, rsp_valid && rsp.rejected, rsp.last && (rsp.tx_byte == '0))
  `SUDF_ASSERT_IMP(a_sync_first, rsp_valid && expect_sync && !rsp.rejected, rsp.tx_byte == SYNC_BYTE)
  `SUDF_ASSERT_IMP(a_no_mid_reject, rsp_valid && !expect_sync, !rsp.rejected)

endmodule

bind stepper_uart_datagram_framer sudf_checker u_sudf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
